// File: rtl/core/dual_sensor_pid_heater_control_top_assert.svh
// Assertion macros for the dual-sensor PID heater controller.
// Included by the top level; needs no package.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef DUAL_SENSOR_PID_HEATER_CONTROL_TOP_ASSERT_SVH
`define DUAL_SENSOR_PID_HEATER_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSHC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DSHC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define DSHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/dshc_pkg.sv
// Shared types and constants of the dual-sensor PID heater controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package dshc_pkg;

    // Field and datapath widths.
    localparam int TEMP_W      = 16;
    localparam int CFG_TEMP_W  = 13;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 16;
    localparam int WORK_W      = 14;  // working temperature, 1/32 C
    localparam int ERR_W       = 15;
    localparam int DIFF_W      = 16;
    localparam int INTEG_W     = 21;
    localparam int ACC_FULL_W  = 32;
    localparam int MUL_A_W     = 38;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Valid sensor window, -100 C to 150 C in 1/16 C.
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd1600;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd2400;

    // Integral clamp, +-100 C*s in units of 2^-13 C*s.
    localparam logic signed [ACC_FULL_W-1:0] INTEG_LIMIT = 32'sd819200;

    // Register reset values.
    localparam logic [CFG_TEMP_W-1:0] TARGET_RST  = 13'd320;
    localparam logic [CFG_TEMP_W-1:0] UPPER_RST   = 13'd640;
    localparam logic [CFG_TEMP_W-1:0] ENABLE_RST  = 13'd240;
    localparam logic [CFG_TEMP_W-1:0] DISABLE_RST = 13'd560;
    localparam logic [GAIN_W-1:0]     GAIN_RST    = 16'd256;
    localparam logic [STEP_W-1:0]     STEP_RST    = 16'd256;

    // Manual command heater codes.
    localparam logic [1:0] HTR_ONE = 2'd0;
    localparam logic [1:0] HTR_TWO = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP   = 3'd0,
        CFG_UPPER_LIMIT   = 3'd1,
        CFG_ENABLE_BELOW  = 3'd2,
        CFG_DISABLE_ABOVE = 3'd3,
        CFG_GAIN_P        = 3'd4,
        CFG_GAIN_I        = 3'd5,
        CFG_GAIN_D        = 3'd6,
        CFG_STEP_TIME     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_AVG  = 2'd1,
        SRC_A    = 2'd2,
        SRC_B    = 2'd3
    } t_source;

    typedef enum logic [1:0] {
        CASE_MANUAL,
        CASE_NO_SENSOR,
        CASE_OVER_LIMIT,
        CASE_PID
    } t_case;

    typedef enum logic [2:0] {
        MUL_ERR_DT,
        MUL_GAIN_P,
        MUL_ACC_DT,
        MUL_GAIN_I,
        MUL_GAIN_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD_P,
        SUM_ADD_I,
        SUM_ADD_D
    } t_sum_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_M_ERR,
        S_M_GP,
        S_M_ACC,
        S_M_GI,
        S_M_GD,
        S_SUM_D,
        S_COMMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     eval;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_load;
        t_sum_op  sum_op;
        logic     commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_pid;
    } t_dp_sts;

    // Result beat, last field in the lowest bit.
    typedef struct packed {
        logic    demand_positive;
        logic    bad_heater;
        logic    heaters_changed;
        logic    shutdown;
        t_source temp_source;
        logic    heater_two_on;
        logic    heater_one_on;
    } t_result;

endpackage

// File: rtl/core/dual_sensor_pid_heater_control_top.sv
// Top level of the dual-sensor PID heater controller; instantiates dshc_ctrl and dshc_dp.
// Depends on dshc_pkg and the assertion macro header.
// Each input beat is a sample pair or a manual heater command, and each gives exactly one
// result beat. A sample pair passes through capture, evaluation, the multiplier steps, the
// final sum and the commit; a manual command or a shutdown case goes from evaluation straight
// to the commit. A new beat is accepted only once the last one is committed. The single shared
// 38x18 signed multiplier forms the five products of a control step one after another (error
// times step time, proportional gain, integral times step time, integral gain, derivative gain).
// A finished result waits in an output register while the next beat is accepted; a step that
// finishes while that register is still full waits until it is taken. Configuration writes are
// accepted in every cycle and must only be issued while the block is idle.
`include "dual_sensor_pid_heater_control_top_assert.svh"

module dual_sensor_pid_heater_control_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input beats.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata from bit 0: temp_a[15:0], temp_b[31:16], heater_select[33:32],
    // heater_enable[34], zero fill [39:35].
    input  logic [dshc_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // tuser: kind (0 sample pair, 1 manual heater command).
    input  logic                                  i_s_axis_tuser,
    // Result beats.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata from bit 0: heater_one_on[0], heater_two_on[1], temp_source[3:2], shutdown[4],
    // heaters_changed[5], bad_heater[6], demand_positive[7].
    output logic [dshc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dshc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dshc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dshc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_result w_res;
    logic    w_cfg_we;

    // Registers are always ready to take a write.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    dshc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dshc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_s_axis_tuser),
        .i_temp_a        (i_s_axis_tdata[15:0]),
        .i_temp_b        (i_s_axis_tdata[31:16]),
        .i_heater_select (i_s_axis_tdata[33:32]),
        .i_heater_enable (i_s_axis_tdata[34]),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_result        (w_res)
    );

    assign o_m_axis_tdata = w_res;

    // Once a beat is taken, the block is busy with it.
    `DSHC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input accepted while a beat was still in work")

    // A commit never overwrites a result that has not been taken.
    `DSHC_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, w_cmd.commit, !o_m_axis_tvalid || i_m_axis_tready, "pending result overwritten")

    // Every commit shows a result in the next cycle.
    `DSHC_ASSERT_NEXT(a_result_after_commit, i_clk, i_rst_n, w_cmd.commit, o_m_axis_tvalid, "commit did not raise the result valid")

    // A rejected manual command touches none of the control-step flags.
    `DSHC_ASSERT_IMPLIES(a_bad_heater_quiet, i_clk, i_rst_n, o_m_axis_tvalid && w_res.bad_heater, !w_res.shutdown && !w_res.heaters_changed && !w_res.demand_positive && (w_res.temp_source == SRC_NONE), "bad heater result carries control-step flags")

endmodule

// File: rtl/core/dshc_ctrl.sv
// Sequencer of the dual-sensor PID heater controller.
// Depends on dshc_pkg; drives the datapath through t_dp_cmd and owns both handshakes.
module dshc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  dshc_pkg::t_dp_sts i_sts,
    output dshc_pkg::t_dp_cmd o_cmd
);
    import dshc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.run_pid ? S_M_ERR : S_COMMIT;
            end
            S_M_ERR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ERR_DT;
                n_state       = S_M_GP;
            end
            S_M_GP: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_GAIN_P;
                n_state        = S_M_ACC;
            end
            S_M_ACC: begin
                o_cmd.sum_op  = SUM_LOAD_P;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ACC_DT;
                n_state       = S_M_GI;
            end
            S_M_GI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN_I;
                n_state       = S_M_GD;
            end
            S_M_GD: begin
                o_cmd.sum_op  = SUM_ADD_I;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN_D;
                n_state       = S_SUM_D;
            end
            S_SUM_D: begin
                o_cmd.sum_op = SUM_ADD_D;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                // Wait until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A pending result clears when taken and sets on commit.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/dshc_dp.sv
// Datapath of the dual-sensor PID heater controller: registers, sensor selection,
// one shared signed multiplier, integral clamp and heater decision. Depends on dshc_pkg.
module dshc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dshc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dshc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_kind,
    input  logic [dshc_pkg::TEMP_W-1:0]         i_temp_a,
    input  logic [dshc_pkg::TEMP_W-1:0]         i_temp_b,
    input  logic [1:0]                          i_heater_select,
    input  logic                                i_heater_enable,
    input  dshc_pkg::t_dp_cmd                   i_cmd,
    output dshc_pkg::t_dp_sts                   o_sts,
    output dshc_pkg::t_result                   o_result
);
    import dshc_pkg::*;

    // Configuration registers.
    logic signed [CFG_TEMP_W-1:0] r_target_temp, r_upper_limit, r_enable_below, r_disable_above;
    logic signed [GAIN_W-1:0]     r_gain_p, r_gain_i, r_gain_d;
    logic [STEP_W-1:0]            r_step_time;

    // Captured input beat.
    logic                     r_kind;
    logic signed [TEMP_W-1:0] r_temp_a, r_temp_b;
    logic [1:0]               r_heater_select;
    logic                     r_heater_enable;

    // Loop state.
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [ERR_W-1:0]   r_last_err, n_last_err;
    logic                      r_heater1, n_heater1, r_heater2, n_heater2;

    // Evaluated sample.
    logic signed [WORK_W-1:0] r_temp;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    t_source                  r_source;
    t_case                    r_case;

    // Arithmetic registers.
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [INTEG_W-1:0] r_acc;
    logic signed [PROD_W-1:0]  r_sum;
    t_result                   r_result, n_result;

    // Combinational signals.
    logic                       w_va, w_vb;
    logic signed [TEMP_W:0]     w_pair_sum;
    logic signed [WORK_W-1:0]   w_temp;
    t_source                    w_source;
    logic signed [WORK_W-1:0]   w_target2, w_upper2, w_enable2, w_disable2;
    logic                       w_over;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [DIFF_W-1:0]   w_diff;
    t_case                      w_case;
    logic signed [STEP_W:0]     w_dt;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_mul_p;
    logic signed [ACC_FULL_W-1:0] w_acc_full;
    logic signed [INTEG_W-1:0]  w_acc_clamp;
    logic                       w_demand;
    logic                       w_next;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_temp   <= TARGET_RST;
            r_upper_limit   <= UPPER_RST;
            r_enable_below  <= ENABLE_RST;
            r_disable_above <= DISABLE_RST;
            r_gain_p        <= GAIN_RST;
            r_gain_i        <= GAIN_RST;
            r_gain_d        <= GAIN_RST;
            r_step_time     <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_TEMP:   r_target_temp   <= i_cfg_data[CFG_TEMP_W-1:0];
                CFG_UPPER_LIMIT:   r_upper_limit   <= i_cfg_data[CFG_TEMP_W-1:0];
                CFG_ENABLE_BELOW:  r_enable_below  <= i_cfg_data[CFG_TEMP_W-1:0];
                CFG_DISABLE_ABOVE: r_disable_above <= i_cfg_data[CFG_TEMP_W-1:0];
                CFG_GAIN_P:        r_gain_p        <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:        r_gain_i        <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:        r_gain_d        <= i_cfg_data[GAIN_W-1:0];
                CFG_STEP_TIME:     r_step_time     <= i_cfg_data[STEP_W-1:0];
            endcase
        end
    end

    // Input capture on the accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind          <= i_kind;
            r_temp_a        <= i_temp_a;
            r_temp_b        <= i_temp_b;
            r_heater_select <= i_heater_select;
            r_heater_enable <= i_heater_enable;
        end
    end

    // Sensor validity and working temperature in 1/32 C.
    assign w_va       = (r_temp_a >= TEMP_MIN) && (r_temp_a <= TEMP_MAX);
    assign w_vb       = (r_temp_b >= TEMP_MIN) && (r_temp_b <= TEMP_MAX);
    assign w_pair_sum = (TEMP_W+1)'(r_temp_a) + (TEMP_W+1)'(r_temp_b);

    always_comb begin
        case ({w_va, w_vb})
            2'b11: begin
                w_temp   = w_pair_sum[WORK_W-1:0];
                w_source = SRC_AVG;
            end
            2'b10: begin
                w_temp   = {r_temp_a[WORK_W-2:0], 1'b0};
                w_source = SRC_A;
            end
            2'b01: begin
                w_temp   = {r_temp_b[WORK_W-2:0], 1'b0};
                w_source = SRC_B;
            end
            default: begin
                w_temp   = '0;
                w_source = SRC_NONE;
            end
        endcase
    end

    // Thresholds scaled to 1/32 C, error and its change.
    assign w_target2  = {r_target_temp, 1'b0};
    assign w_upper2   = {r_upper_limit, 1'b0};
    assign w_enable2  = {r_enable_below, 1'b0};
    assign w_disable2 = {r_disable_above, 1'b0};
    assign w_over     = (w_temp >= w_upper2);
    assign w_err      = ERR_W'(w_target2) - ERR_W'(w_temp);
    assign w_diff     = DIFF_W'(w_err) - DIFF_W'(r_last_err);

    // Classify the beat.
    always_comb begin
        if (r_kind) begin
            w_case = CASE_MANUAL;
        end else if (!w_va && !w_vb) begin
            w_case = CASE_NO_SENSOR;
        end else if (w_over) begin
            w_case = CASE_OVER_LIMIT;
        end else begin
            w_case = CASE_PID;
        end
    end

    assign o_sts.run_pid = (w_case == CASE_PID);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_temp   <= w_temp;
            r_err    <= w_err;
            r_diff   <= w_diff;
            r_source <= w_source;
            r_case   <= w_case;
        end
    end

    // A step time of zero counts as one.
    assign w_dt = {1'b0, (r_step_time == '0) ? STEP_W'(1) : r_step_time};

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_DT: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'(w_dt);
            end
            MUL_GAIN_P: begin
                w_mul_a = MUL_A_W'($signed(r_prod[30:0]));
                w_mul_b = MUL_B_W'(r_gain_p);
            end
            MUL_ACC_DT: begin
                w_mul_a = MUL_A_W'(r_acc);
                w_mul_b = MUL_B_W'(w_dt);
            end
            MUL_GAIN_I: begin
                w_mul_a = $signed(r_prod[MUL_A_W-1:0]);
                w_mul_b = MUL_B_W'(r_gain_i);
            end
            MUL_GAIN_D: begin
                w_mul_a = MUL_A_W'(r_diff);
                w_mul_b = MUL_B_W'(r_gain_d);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_mul_p;
        end
    end

    // New integral from error times step time, clamped to the limit.
    assign w_acc_full = ACC_FULL_W'(r_integ) + ACC_FULL_W'($signed(r_prod[30:0]));

    always_comb begin
        if (w_acc_full > INTEG_LIMIT) begin
            w_acc_clamp = INTEG_LIMIT[INTEG_W-1:0];
        end else if (w_acc_full < -INTEG_LIMIT) begin
            w_acc_clamp = INTEG_W'(-INTEG_LIMIT);
        end else begin
            w_acc_clamp = w_acc_full[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc <= w_acc_clamp;
        end
    end

    // Scaled PID sum: P term shifted by 8, I term as is, D term shifted by 16.
    always_ff @(posedge i_clk) begin
        case (i_cmd.sum_op)
            SUM_LOAD_P: r_sum <= {r_prod[PROD_W-9:0], 8'h00};
            SUM_ADD_I:  r_sum <= r_sum + r_prod;
            SUM_ADD_D:  r_sum <= r_sum + {r_prod[PROD_W-17:0], 16'h0000};
            default:    r_sum <= r_sum;
        endcase
    end

    assign w_demand = (r_sum > 0);

    // Heater decision with hysteresis.
    always_comb begin
        if (w_demand && (r_temp < w_enable2)) begin
            w_next = 1'b1;
        end else if (!w_demand || (r_temp > w_disable2)) begin
            w_next = 1'b0;
        end else begin
            w_next = r_heater1;
        end
    end

    // Loop state update and result for the finished item.
    always_comb begin
        n_heater1  = r_heater1;
        n_heater2  = r_heater2;
        n_integ    = r_integ;
        n_last_err = r_last_err;
        n_result   = '0;
        case (r_case)
            CASE_MANUAL: begin
                case (r_heater_select)
                    HTR_ONE: n_heater1 = r_heater_enable;
                    HTR_TWO: n_heater2 = r_heater_enable;
                    default: n_result.bad_heater = 1'b1;
                endcase
            end
            CASE_NO_SENSOR: begin
                n_heater1                = 1'b0;
                n_heater2                = 1'b0;
                n_integ                  = '0;
                n_last_err               = '0;
                n_result.shutdown        = 1'b1;
                n_result.heaters_changed = 1'b1;
            end
            CASE_OVER_LIMIT: begin
                n_result.shutdown    = 1'b1;
                n_result.temp_source = r_source;
                if (r_heater1 || r_heater2) begin
                    n_heater1                = 1'b0;
                    n_heater2                = 1'b0;
                    n_integ                  = '0;
                    n_last_err               = '0;
                    n_result.heaters_changed = 1'b1;
                end
            end
            default: begin
                n_result.temp_source     = r_source;
                n_result.demand_positive = w_demand;
                n_integ                  = r_acc;
                n_last_err               = r_err;
                if ((w_next != r_heater1) || (w_next != r_heater2)) begin
                    n_heater1                = w_next;
                    n_heater2                = w_next;
                    n_result.heaters_changed = 1'b1;
                end
            end
        endcase
        n_result.heater_one_on = n_heater1;
        n_result.heater_two_on = n_heater2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater1  <= 1'b0;
            r_heater2  <= 1'b0;
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (i_cmd.commit) begin
            r_heater1  <= n_heater1;
            r_heater2  <= n_heater2;
            r_integ    <= n_integ;
            r_last_err <= n_last_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
